// ===== sv/assert_macros.svh =====
// Assertion helpers for the clearance block; clk and rst are taken from the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the condition holds in the same cycle as the trigger.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that the condition holds in the cycle after the trigger.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ssc_pkg.sv =====
`timescale 1ns / 1ps
package ssc_pkg;

  // Opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_PAIR   = 2'd2;

  // Sample phases
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_MID   = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  // Verdict kinds
  localparam logic KIND_CLEARANCE = 1'b0;
  localparam logic KIND_PAIR      = 1'b1;

  // Register indexes
  localparam logic REG_SAFETY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam int SAFETY_W = 12;
  localparam int COUNT_W  = 7;
  localparam int RAD_W    = 23;
  localparam int SWEPT_W  = 26;

  localparam logic [SAFETY_W-1:0] SAFETY_RESET = 12'd512;
  localparam logic [SWEPT_W-1:0]  SWEPT_MAX    = 26'h3FF_FFFF;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         slot_a;
    logic [4:0]         slot_b;
    logic [1:0]         phase;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [22:0]        radius_in;
  } in_word_t;

  typedef struct packed {
    logic       verdict_kind;
    logic [4:0] verdict_slot;
    logic       clear_flag;
  } out_word_t;

endpackage

// ===== sv/ssc_root.sv =====
`timescale 1ns / 1ps
// Bit-by-bit integer square root of a 64-bit value, one result bit per cycle.
module ssc_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root,
  output logic        rem_nz
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial  = res + bitv;
  assign root   = res[31:0];
  assign rem_nz = (rem != 64'd0);

  // Step through the result bits, top first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= radicand;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/swept_sphere_clearance.sv =====
`timescale 1ns / 1ps
// Loads and start/middle samples only write tables or registers; a pair query computes
// one distance (none when a slot is out of range); an end sample computes three, then one
// per scanned obstacle. One item at a time; the shared 32-step square root unit sets the
// pace. A finished word waits in the output register while stalled.
// Reset (rst, synchronous): sequencer idle, no word pending, safety factor 2.0,
// obstacle count 0. Obstacle and swept tables are not cleared.
module swept_sphere_clearance #(
  parameter int MAX_OBSTACLES = 64,
  parameter int MAX_SPHERES   = 32,
  parameter int COORD_BITS    = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ssc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ssc_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_data
);

  localparam int OW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int SW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW = $clog2(MAX_OBSTACLES + 1);
  localparam int DW = COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t                        x;
    coord_t                        y;
    coord_t                        z;
    logic [ssc_pkg::RAD_W-1:0]     r;
  } obst_t;

  typedef struct packed {
    coord_t                        x;
    coord_t                        y;
    coord_t                        z;
    logic [ssc_pkg::SWEPT_W-1:0]   r;
  } swept_t;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL   = 12'b0000_0000_0010,
    S_ACC   = 12'b0000_0000_0100,
    S_RGO   = 12'b0000_0000_1000,
    S_ROOT  = 12'b0000_0001_0000,
    S_POST  = 12'b0000_0010_0000,
    S_SCALE = 12'b0000_0100_0000,
    S_RAD   = 12'b0000_1000_0000,
    S_ORD   = 12'b0001_0000_0000,
    S_PRA   = 12'b0010_0000_0000,
    S_PRB   = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    J_D0   = 3'd0,
    J_D2   = 3'd1,
    J_SAG  = 3'd2,
    J_OBS  = 3'd3,
    J_PAIR = 3'd4
  } job_t;

  state_t state;
  job_t   job;

  logic [ssc_pkg::SAFETY_W-1:0] safety;
  logic [ssc_pkg::COUNT_W-1:0]  obstacle_count;

  obst_t  omem [MAX_OBSTACLES];
  swept_t smem [MAX_SPHERES];
  obst_t  rd_o;
  swept_t rd_s;

  coord_t st0 [3];
  coord_t st1 [3];
  coord_t pt  [3];
  logic [ssc_pkg::RAD_W-1:0] st_r0, st_r1, prad;

  logic [5:0]    slot_a;
  logic [4:0]    slot_b;
  logic [1:0]    k;
  logic [CW-1:0] i;
  logic [CW-1:0] n_lim;
  logic [63:0]   mul;
  logic [63:0]   acc;
  logic [64:0]   acc_sum;
  logic [32:0]   dev;
  logic [ssc_pkg::SWEPT_W-1:0] sag;
  logic [ssc_pkg::SWEPT_W-1:0] rad;
  logic          res_kind;
  logic          res_clear;

  logic          root_done;
  logic [31:0]   root;
  logic          rem_nz;
  logic [32:0]   root_c;

  coord_t        o_ax, b_ax;
  logic signed [DW-1:0] diff;
  logic [DW-1:0] mag;
  logic [63:0]   mag64;
  logic [31:0]   sq_op, mul_a, mul_b;
  logic [ssc_pkg::RAD_W-1:0]   maxr;
  logic [39:0]   scaled, sum40;
  logic [ssc_pkg::SWEPT_W-1:0] rad_calc;
  logic [ssc_pkg::SWEPT_W-1:0] orad;
  logic [26:0]   cmp_sum;
  logic          beyond;
  logic [SW-1:0] s_raddr;
  logic          in_acc;
  logic          out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Limit the scan to the table depth
  assign n_lim = (32'(obstacle_count) > 32'(MAX_OBSTACLES)) ? CW'(MAX_OBSTACLES)
                                                            : CW'(obstacle_count);

  // Pick one axis of each operand
  always_comb begin
    case (k)
      2'd0: begin
        o_ax = rd_o.x;
        b_ax = rd_s.x;
      end
      2'd1: begin
        o_ax = rd_o.y;
        b_ax = rd_s.y;
      end
      default: begin
        o_ax = rd_o.z;
        b_ax = rd_s.z;
      end
    endcase
  end

  // Form the coordinate difference for the current distance
  always_comb begin
    case (job)
      J_D0:    diff = DW'(st0[k]) - DW'(st1[k]);
      J_D2:    diff = DW'(pt[k]) - DW'(st1[k]);
      J_SAG:   diff = DW'(st0[k]) + DW'(pt[k]) - (DW'(st1[k]) <<< 1);
      J_OBS:   diff = DW'(st1[k]) - DW'(o_ax);
      J_PAIR:  diff = DW'(pt[k]) - DW'(b_ax);
      default: diff = '0;
    endcase
  end

  // Cap the magnitude to 32 bits and share the multiplier with the sag scaling
  assign mag   = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign mag64 = 64'(mag);
  assign sq_op = (mag64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag64[31:0];
  assign mul_a = (state == S_SCALE) ? 32'(sag) : sq_op;
  assign mul_b = (state == S_SCALE) ? 32'(safety) : sq_op;

  assign acc_sum = {1'b0, acc} + {1'b0, mul};
  assign root_c  = 33'(root) + 33'(rem_nz);

  // Swept radius from deviation, largest radius and scaled sag
  always_comb begin
    maxr = st_r0;
    if (st_r1 > maxr) maxr = st_r1;
    if (prad > maxr) maxr = prad;
    scaled   = (40'(mul) + 40'd255) >> 8;
    sum40    = 40'(dev) + 40'(maxr) + scaled;
    rad_calc = (sum40 > 40'(ssc_pkg::SWEPT_MAX)) ? ssc_pkg::SWEPT_MAX
                                                  : sum40[ssc_pkg::SWEPT_W-1:0];
  end

  // Clearance compare against the floor distance
  assign orad    = (job == J_PAIR) ? rd_s.r : ssc_pkg::SWEPT_W'(rd_o.r);
  assign cmp_sum = 27'(rad) + 27'(orad);
  assign beyond  = 33'(root) > 33'(cmp_sum);

  ssc_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_RGO),
    .radicand (acc),
    .done     (root_done),
    .root     (root),
    .rem_nz   (rem_nz)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      safety         <= ssc_pkg::SAFETY_RESET;
      obstacle_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssc_pkg::REG_SAFETY: safety <= cfg_data[ssc_pkg::SAFETY_W-1:0];
        ssc_pkg::REG_COUNT:  obstacle_count <= cfg_data[ssc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Obstacle table: write on load, read the scan entry every cycle
  always_ff @(posedge clk) begin
    if (in_acc && in_data.opcode == ssc_pkg::OP_LOAD
        && 32'(in_data.slot_a) < 32'(MAX_OBSTACLES)) begin
      omem[OW'(in_data.slot_a)] <= '{x: COORD_BITS'(in_data.pos_x),
                                     y: COORD_BITS'(in_data.pos_y),
                                     z: COORD_BITS'(in_data.pos_z),
                                     r: in_data.radius_in};
    end
    rd_o <= omem[i[OW-1:0]];
  end

  // Swept table: write the new sphere, read first then second pair entry
  assign s_raddr = (state == S_PRA) ? SW'(slot_a) : SW'(slot_b);
  always_ff @(posedge clk) begin
    if (state == S_RAD) begin
      smem[SW'(slot_a)] <= '{x: st1[0], y: st1[1], z: st1[2], r: rad_calc};
    end
    rd_s <= smem[s_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= J_D0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            slot_a <= in_data.slot_a;
            slot_b <= in_data.slot_b;
            case (in_data.opcode)
              ssc_pkg::OP_SAMPLE: begin
                if (32'(in_data.slot_a) < 32'(MAX_SPHERES)) begin
                  case (in_data.phase)
                    ssc_pkg::PH_START: begin
                      st0[0] <= COORD_BITS'(in_data.pos_x);
                      st0[1] <= COORD_BITS'(in_data.pos_y);
                      st0[2] <= COORD_BITS'(in_data.pos_z);
                      st_r0  <= in_data.radius_in;
                    end
                    ssc_pkg::PH_MID: begin
                      st1[0] <= COORD_BITS'(in_data.pos_x);
                      st1[1] <= COORD_BITS'(in_data.pos_y);
                      st1[2] <= COORD_BITS'(in_data.pos_z);
                      st_r1  <= in_data.radius_in;
                    end
                    ssc_pkg::PH_END: begin
                      pt[0]     <= COORD_BITS'(in_data.pos_x);
                      pt[1]     <= COORD_BITS'(in_data.pos_y);
                      pt[2]     <= COORD_BITS'(in_data.pos_z);
                      prad      <= in_data.radius_in;
                      job       <= J_D0;
                      k         <= 2'd0;
                      acc       <= '0;
                      res_kind  <= ssc_pkg::KIND_CLEARANCE;
                      res_clear <= 1'b1;
                      state     <= S_MUL;
                    end
                    default: ;
                  endcase
                end
              end
              ssc_pkg::OP_PAIR: begin
                res_kind  <= ssc_pkg::KIND_PAIR;
                res_clear <= 1'b0;
                if (32'(in_data.slot_a) < 32'(MAX_SPHERES)
                    && 32'(in_data.slot_b) < 32'(MAX_SPHERES)) begin
                  state <= S_PRA;
                end else begin
                  state <= S_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          mul   <= 64'(mul_a) * 64'(mul_b);
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
          if (k == 2'd2) begin
            state <= S_RGO;
          end else begin
            k     <= k + 2'd1;
            state <= S_MUL;
          end
        end
        S_RGO: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) state <= S_POST;
        end
        S_POST: begin
          k   <= 2'd0;
          acc <= '0;
          case (job)
            J_D0: begin
              dev   <= root_c;
              job   <= J_D2;
              state <= S_MUL;
            end
            J_D2: begin
              if (root_c > dev) dev <= root_c;
              job   <= J_SAG;
              state <= S_MUL;
            end
            J_SAG: begin
              sag   <= (root_c > 33'(ssc_pkg::SWEPT_MAX)) ? ssc_pkg::SWEPT_MAX
                                                          : root_c[ssc_pkg::SWEPT_W-1:0];
              state <= S_SCALE;
            end
            J_OBS: begin
              if (!beyond) res_clear <= 1'b0;
              i <= i + CW'(1);
              if (CW'(i + CW'(1)) == n_lim) begin
                state <= S_DONE;
              end else begin
                state <= S_ORD;
              end
            end
            default: begin
              res_clear <= beyond;
              state     <= S_DONE;
            end
          endcase
        end
        S_SCALE: begin
          mul   <= 64'(mul_a) * 64'(mul_b);
          state <= S_RAD;
        end
        S_RAD: begin
          rad <= rad_calc;
          i   <= '0;
          job <= J_OBS;
          if (n_lim == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_ORD;
          end
        end
        S_ORD: begin
          state <= S_MUL;
        end
        S_PRA: begin
          state <= S_PRB;
        end
        S_PRB: begin
          // Hold the first sphere; the second follows from the table next cycle
          pt[0] <= rd_s.x;
          pt[1] <= rd_s.y;
          pt[2] <= rd_s.z;
          rad   <= rd_s.r;
          job   <= J_PAIR;
          k     <= 2'd0;
          acc   <= '0;
          state <= S_MUL;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data <= '{verdict_kind: res_kind, verdict_slot: slot_a[4:0], clear_flag: res_clear};
    end
  end

endmodule

// ===== sv/ssc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks of the clearance block.
module ssc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input ssc_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ssc_pkg::out_word_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  logic in_acc;
  logic pair_item;
  logic quick_item;

  // Classify the accepted input word
  assign in_acc     = in_valid && !in_stall;
  assign pair_item  = in_acc && in_data.opcode == ssc_pkg::OP_PAIR;
  assign quick_item = in_acc && (in_data.opcode == ssc_pkg::OP_LOAD
                      || (in_data.opcode == ssc_pkg::OP_SAMPLE
                          && in_data.phase != ssc_pkg::PH_END));

  // A stalled result word stays and holds its value
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))

  // A pair query always keeps the block busy for the next cycle
  `ASSERT_NEXT(a_pair_busy, pair_item, in_stall)

  // Loads and start or middle samples finish at once
  `ASSERT_NEXT(a_quick_items, quick_item, !in_stall)

  // Configuration is always taken
  `ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind swept_sphere_clearance ssc_checker u_ssc_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] PH_UNUSED = 2'd3;
  localparam int N_OBST   = 64;
  localparam int N_SPHERE = 32;
  localparam int DRAIN    = 64;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  ssc_pkg::in_word_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  ssc_pkg::out_word_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = ssc_pkg::REG_SAFETY;
  logic [11:0] cfg_data = '0;

  swept_sphere_clearance u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  longint      obs_x[N_OBST], obs_y[N_OBST], obs_z[N_OBST];
  logic [63:0] obs_r[N_OBST];
  longint      sw_x[N_SPHERE], sw_y[N_SPHERE], sw_z[N_SPHERE];
  logic [63:0] sw_r[N_SPHERE];
  longint      stg_x[2], stg_y[2], stg_z[2];
  logic [63:0] stg_r[2];
  logic [63:0] safety = 64'(ssc_pkg::SAFETY_RESET);
  logic [63:0] obst_count = '0;

  // stimulus side bookkeeping: what has been formed or staged so far
  bit          gen_formed[N_SPHERE];
  bit          gen_staged[2];

  ssc_pkg::in_word_t  word_queue[$];
  ssc_pkg::out_word_t pending_verdicts[$];
  int          fail_count = 0;
  int          issued = 0;
  int          accepted_words = 0;
  int          clear_verdicts = 0, blocked_verdicts = 0, pair_verdicts = 0;
  int          gap_left = 0, stall_left = 0;
  bit          calm_in = 0, calm_out = 0;
  bit          has_verdict;
  ssc_pkg::out_word_t next_verdict, due;

  function automatic logic [63:0] capped_sq(longint d);
    logic [63:0] mag;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
    return mag * mag;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] dist_sq(longint dx, longint dy, longint dz);
    return sat_add(sat_add(capped_sq(dx), capped_sq(dy)), capped_sq(dz));
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bt;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] root_ceil(logic [63:0] v);
    logic [63:0] r;
    r = root_floor(v);
    return (r * r < v) ? r + 64'd1 : r;
  endfunction

  // Advance the predictor by one accepted word
  task automatic predict_verdict(input ssc_pkg::in_word_t w, output bit has,
                                 output ssc_pkg::out_word_t v);
    longint x, y, z;
    logic [63:0] r, d0, d2, dev, maxr, sag, rad, n, d;
    int a, b, ph;
    bit clear;
    x = longint'(w.pos_x);
    y = longint'(w.pos_y);
    z = longint'(w.pos_z);
    r = 64'(w.radius_in);
    a = int'(w.slot_a);
    b = int'(w.slot_b);
    ph = int'(w.phase);
    has = 0;
    v = '0;
    case (w.opcode)
      ssc_pkg::OP_LOAD: begin
        obs_x[a] = x; obs_y[a] = y; obs_z[a] = z; obs_r[a] = r;
      end
      ssc_pkg::OP_SAMPLE: begin
        if (a < N_SPHERE && w.phase != PH_UNUSED) begin
          if (w.phase != ssc_pkg::PH_END) begin
            stg_x[ph] = x; stg_y[ph] = y; stg_z[ph] = z; stg_r[ph] = r;
          end else begin
            d0 = root_ceil(dist_sq(stg_x[0] - stg_x[1], stg_y[0] - stg_y[1],
                                   stg_z[0] - stg_z[1]));
            d2 = root_ceil(dist_sq(x - stg_x[1], y - stg_y[1], z - stg_z[1]));
            dev = (d0 > d2) ? d0 : d2;
            maxr = stg_r[0];
            if (stg_r[1] > maxr) maxr = stg_r[1];
            if (r > maxr) maxr = r;
            sag = root_ceil(dist_sq(stg_x[0] + x - 2 * stg_x[1],
                                    stg_y[0] + y - 2 * stg_y[1],
                                    stg_z[0] + z - 2 * stg_z[1]));
            if (sag > 64'(ssc_pkg::SWEPT_MAX)) sag = 64'(ssc_pkg::SWEPT_MAX);
            sag = (sag * safety + 64'd255) >> 8;
            rad = dev + maxr + sag;
            if (rad > 64'(ssc_pkg::SWEPT_MAX)) rad = 64'(ssc_pkg::SWEPT_MAX);
            sw_x[a] = stg_x[1]; sw_y[a] = stg_y[1]; sw_z[a] = stg_z[1]; sw_r[a] = rad;
            n = (obst_count > 64'(N_OBST)) ? 64'(N_OBST) : obst_count;
            clear = 1;
            for (int i = 0; i < n; i++) begin
              d = root_floor(dist_sq(stg_x[1] - obs_x[i], stg_y[1] - obs_y[i],
                                     stg_z[1] - obs_z[i]));
              if (!(d > rad + obs_r[i])) clear = 0;
            end
            has = 1;
            v.verdict_kind = ssc_pkg::KIND_CLEARANCE;
            v.verdict_slot = 5'(a);
            v.clear_flag = clear;
          end
        end
      end
      ssc_pkg::OP_PAIR: begin
        clear = 0;
        if (a < N_SPHERE) begin
          d = root_floor(dist_sq(sw_x[a] - sw_x[b], sw_y[a] - sw_y[b], sw_z[a] - sw_z[b]));
          clear = d > sw_r[a] + sw_r[b];
        end
        has = 1;
        v.verdict_kind = ssc_pkg::KIND_PAIR;
        v.verdict_slot = 5'(a);
        v.clear_flag = clear;
      end
      default: ;
    endcase
  endtask

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int draw_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Feed words from the queue and predict each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_verdict(in_data, has_verdict, next_verdict);
        if (has_verdict) pending_verdicts.insert(pending_verdicts.size(), next_verdict);
        accepted_words++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          in_data <= word_queue.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 99) == 0) calm_in = !calm_in;
          gap_left = draw_gap(calm_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) == 0) calm_out = !calm_out;
      stall_left = draw_gap(calm_out);
    end
  end

  // Check each verdict word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report($sformatf("unexpected verdict %p", out_data));
      end else begin
        due = pending_verdicts.pop_front();
        if (out_data.verdict_kind != due.verdict_kind)
          report($sformatf("verdict_kind %0d, want %0d", out_data.verdict_kind,
                           due.verdict_kind));
        if (out_data.verdict_slot != due.verdict_slot)
          report($sformatf("verdict_slot %0d, want %0d", out_data.verdict_slot,
                           due.verdict_slot));
        if (out_data.clear_flag != due.clear_flag)
          report($sformatf("clear_flag %0d, want %0d (slot %0d kind %0d)",
                           out_data.clear_flag, due.clear_flag, due.verdict_slot,
                           due.verdict_kind));
        if (due.verdict_kind == ssc_pkg::KIND_PAIR) pair_verdicts++;
        else if (due.clear_flag) clear_verdicts++;
        else blocked_verdicts++;
      end
    end
  end

  function automatic ssc_pkg::in_word_t mk(logic [1:0] op, int a, int b, logic [1:0] ph,
                                           int x, int y, int z, int r);
    ssc_pkg::in_word_t w;
    w.opcode = op;
    w.slot_a = 6'(a);
    w.slot_b = 5'(b);
    w.phase = ph;
    w.pos_x = x[23:0];
    w.pos_y = y[23:0];
    w.pos_z = z[23:0];
    w.radius_in = r[22:0];
    return w;
  endfunction

  // Queue a word and track what it leaves staged or formed
  task automatic push_word(input ssc_pkg::in_word_t w);
    word_queue.insert(word_queue.size(), w);
    issued++;
    if (w.opcode == ssc_pkg::OP_SAMPLE && w.slot_a < N_SPHERE) begin
      if (w.phase == ssc_pkg::PH_START || w.phase == ssc_pkg::PH_MID)
        gen_staged[w.phase] = 1;
      else if (w.phase == ssc_pkg::PH_END) gen_formed[w.slot_a] = 1;
    end
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 16777215)) - 8388608;
    return int'($urandom_range(0, 524288)) - 262144;
  endfunction

  function automatic int rand_radius();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 8388607));
    return int'($urandom_range(0, 65535));
  endfunction

  function automatic int near(int c);
    int s, v;
    case ($urandom_range(0, 3))
      0: s = 4096;
      1: s = 65536;
      2: s = 1048576;
      default: return rand_coord();
    endcase
    v = c + int'($urandom_range(0, 2 * s)) - s;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  task automatic push_sample(int slot, logic [1:0] ph, int cx, int cy, int cz);
    push_word(mk(ssc_pkg::OP_SAMPLE, slot, $urandom_range(0, 31), ph, near(cx), near(cy),
                 near(cz), rand_radius()));
  endtask

  // One random chunk of stimulus: most often a complete three-point motion
  task automatic gen_random();
    int sel, s, cx, cy, cz;
    int formed_list[$];
    sel = $urandom_range(0, 99);
    s = $urandom_range(0, N_SPHERE - 1);
    cx = rand_coord(); cy = rand_coord(); cz = rand_coord();
    if (sel < 45) begin
      push_word(mk(ssc_pkg::OP_SAMPLE, s, $urandom_range(0, 31), ssc_pkg::PH_START,
                   near(cx), near(cy), near(cz), rand_radius()));
      push_word(mk(ssc_pkg::OP_SAMPLE, s, $urandom_range(0, 31), ssc_pkg::PH_MID,
                   cx, cy, cz, rand_radius()));
      push_sample(s, ssc_pkg::PH_END, cx, cy, cz);
    end else if (sel < 58) begin
      push_word(mk(ssc_pkg::OP_LOAD, $urandom_range(0, N_OBST - 1), $urandom_range(0, 31),
                   2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(),
                   rand_radius()));
    end else if (sel < 80) begin
      for (int i = 0; i < N_SPHERE; i++)
        if (gen_formed[i]) formed_list.insert(formed_list.size(), i);
      if (formed_list.size() == 0 || $urandom_range(0, 7) == 0) begin
        push_word(mk(ssc_pkg::OP_PAIR, $urandom_range(N_SPHERE, 63), $urandom_range(0, 31),
                     2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(),
                     rand_radius()));
      end else begin
        push_word(mk(ssc_pkg::OP_PAIR, formed_list[$urandom_range(0, formed_list.size() - 1)],
                     formed_list[$urandom_range(0, formed_list.size() - 1)],
                     2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(),
                     rand_radius()));
      end
    end else if (sel < 90) begin
      // broken motion: a point is missing, the stale staged one is reused
      if ($urandom_range(0, 1) && gen_staged[1]) begin
        push_sample(s, ssc_pkg::PH_START, cx, cy, cz);
        push_sample(s, ssc_pkg::PH_END, cx, cy, cz);
      end else if (gen_staged[0]) begin
        push_sample(s, ssc_pkg::PH_MID, cx, cy, cz);
        push_sample(s, ssc_pkg::PH_END, cx, cy, cz);
      end else begin
        push_sample(s, ssc_pkg::PH_MID, cx, cy, cz);
      end
    end else begin
      // ignored words: unused opcode, unused phase, sphere slot out of range
      case ($urandom_range(0, 2))
        0: push_word(mk(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 31),
                        2'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                        rand_coord(), rand_radius()));
        1: push_word(mk(ssc_pkg::OP_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 31),
                        PH_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                        rand_radius()));
        default: push_word(mk(ssc_pkg::OP_SAMPLE, $urandom_range(N_SPHERE, 63),
                              $urandom_range(0, 31), 2'($urandom_range(0, 2)),
                              rand_coord(), rand_coord(), rand_coord(), rand_radius()));
      endcase
    end
  endtask

  // Wait until every word is in and every verdict out, then let the block settle
  task automatic wait_idle();
    do @(posedge clk);
    while (word_queue.size() != 0 || in_valid || pending_verdicts.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    cfg_index <= idx;
    cfg_data <= 12'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ssc_pkg::REG_SAFETY) safety = 64'(value & 12'hFFF);
    else obst_count = 64'(value & 7'h7F);
  endtask

  task automatic run_phase(input int sf, input int cnt, input int n);
    int start;
    wait_idle();
    write_reg(ssc_pkg::REG_SAFETY, sf);
    write_reg(ssc_pkg::REG_COUNT, cnt);
    start = issued;
    while (issued - start < n) gen_random();
  endtask

  initial begin
    int sf_list[9], cnt_list[9], n_list[9];
    sf_list  = '{512, 512, 0, 4095, 128, 256, 4095, 1, 0};
    cnt_list = '{0, 4, 1, 8, 2, 64, 127, 3, 0};
    n_list   = '{200, 260, 220, 260, 220, 70, 50, 250, 150};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, saturation, ignored words, pairs with no obstacles
    push_word(mk(ssc_pkg::OP_LOAD, 0, 0, ssc_pkg::PH_START, 8388607, 8388607, 8388607,
                 8388607));
    push_word(mk(ssc_pkg::OP_LOAD, 63, 31, PH_UNUSED, -8388608, -8388608, -8388608, 0));
    push_word(mk(ssc_pkg::OP_SAMPLE, 0, 0, ssc_pkg::PH_START, -8388608, -8388608, -8388608,
                 8388607));
    push_word(mk(ssc_pkg::OP_SAMPLE, 0, 0, ssc_pkg::PH_MID, 8388607, 8388607, 8388607, 0));
    push_word(mk(ssc_pkg::OP_SAMPLE, 0, 0, ssc_pkg::PH_END, -8388608, -8388608, -8388608,
                 0));
    push_word(mk(ssc_pkg::OP_SAMPLE, 31, 31, ssc_pkg::PH_START, 0, 0, 0, 0));
    push_word(mk(ssc_pkg::OP_SAMPLE, 31, 31, ssc_pkg::PH_MID, 0, 0, 0, 0));
    push_word(mk(ssc_pkg::OP_SAMPLE, 31, 31, ssc_pkg::PH_END, 0, 0, 0, 0));
    push_word(mk(ssc_pkg::OP_SAMPLE, 32, 0, ssc_pkg::PH_END, 100, 100, 100, 5));
    push_word(mk(ssc_pkg::OP_SAMPLE, 5, 0, PH_UNUSED, 100, 100, 100, 5));
    push_word(mk(OP_UNUSED, 63, 31, PH_UNUSED, -1, -1, -1, 8388607));
    push_word(mk(ssc_pkg::OP_SAMPLE, 63, 31, ssc_pkg::PH_START, 1, 2, 3, 4));
    push_word(mk(ssc_pkg::OP_PAIR, 0, 31, ssc_pkg::PH_START, 0, 0, 0, 0));
    push_word(mk(ssc_pkg::OP_PAIR, 31, 31, ssc_pkg::PH_START, 0, 0, 0, 0));
    push_word(mk(ssc_pkg::OP_PAIR, 40, 0, ssc_pkg::PH_START, 0, 0, 0, 0));
    push_word(mk(ssc_pkg::OP_PAIR, 63, 31, ssc_pkg::PH_START, 0, 0, 0, 0));
    push_word(mk(ssc_pkg::OP_PAIR, 0, 0, ssc_pkg::PH_START, 0, 0, 0, 0));
    push_word(mk(ssc_pkg::OP_SAMPLE, 7, 0, ssc_pkg::PH_START, 65536, 0, 0, 256));
    push_word(mk(ssc_pkg::OP_SAMPLE, 7, 0, ssc_pkg::PH_MID, 65536, 65536, 0, 256));
    push_word(mk(ssc_pkg::OP_SAMPLE, 7, 0, ssc_pkg::PH_END, 131072, 65536, 0, 512));

    // fill the whole obstacle table before any scan is enabled
    wait_idle();
    for (int i = 0; i < N_OBST; i++)
      push_word(mk(ssc_pkg::OP_LOAD, i, $urandom_range(0, 31), 2'($urandom_range(0, 3)),
                   rand_coord(), rand_coord(), rand_coord(), rand_radius()));

    for (int p = 0; p < 9; p++) run_phase(sf_list[p], cnt_list[p], n_list[p]);
    wait_idle();

    $display("%0d words accepted over 9 register settings (safety 0..4095, obstacles 0..127)",
             accepted_words);
    $display("clearance verdicts: %0d clear, %0d blocked; pair verdicts: %0d",
             clear_verdicts, blocked_verdicts, pair_verdicts);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #250ms;
    $display("timeout with %0d verdicts outstanding", pending_verdicts.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/ssc_pkg.sv
sv/ssc_root.sv
sv/swept_sphere_clearance.sv
sv/ssc_checker.sv
sim/testbench.sv
